[design/hvd_pkg.sv]
// hvd_pkg: constants, lookup tables and elaboration helpers for the haversine distance block
// depends on nothing; used by haversine_distance and hvd_check
`timescale 1ns / 1ps
`default_nettype none

package hvd_pkg;

  // field widths
  localparam int ANGLE_FRAC_BITS = 22;
  localparam int LAT_W           = 30;
  localparam int LON_W           = 31;
  localparam int DIST_W          = 29;
  localparam int DIST_MAX        = 320241840;

  // phase: 2^32 is a full turn
  localparam int SH_HALF  = 28 - ANGLE_FRAC_BITS;
  localparam int SH_FULL  = 29 - ANGLE_FRAC_BITS;
  localparam int PH_RND   = 22;
  localparam int DIV_CORE = 45;
  localparam int MW       = 33 + SH_FULL;

  // residue mod 45 by 12-bit folding, since 2^12 = 1 mod 45
  localparam int CHUNK_W  = 12;
  localparam int NCH      = (MW + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W    = NCH * CHUNK_W;
  localparam int SUM_W    = 16;
  localparam int V_W      = CHUNK_W + 1;
  localparam int RCP_W    = 11;
  localparam int RCP_SH   = 16;
  localparam int RECIP45  = 1456;
  localparam int QV_W     = 7;
  localparam int R1_W     = 7;
  localparam int R_W      = 6;

  // cordic and fixed point
  localparam int CORDIC_STAGES   = 30;
  localparam int CORDIC_W        = 34;
  localparam int Q30_ONE         = 1 << 30;
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int Q_W             = 31;
  localparam int SQ_W            = 62;
  localparam int SQ_STEPS        = 31;
  localparam int DPROD_W         = 64;
  localparam logic [31:0] DIST_SCALE = 32'd1280967324;

  localparam logic [31:0] ATAN_PHASE [CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // multiplicative inverse of an odd value mod 2^32 (newton iteration)
  function automatic logic [31:0] inv_odd32(input logic [31:0] a);
    logic [31:0] x;
    x = a;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - a * x);
    end
    return x;
  endfunction

  // 2^e mod 45
  function automatic int pow2_mod45(input int e);
    int v;
    v = 1;
    for (int i = 0; i < e; i++) begin
      v = (v * 2) % DIV_CORE;
    end
    return v;
  endfunction

  localparam logic [31:0] INV45   = inv_odd32(32'd45);
  localparam int          NEG_ADJ = DIV_CORE - pow2_mod45(MW);

endpackage

`default_nettype wire

[design/haversine_distance.sv]
// haversine_distance: pipelined great-circle distance between two lat/lon points
// depends on hvd_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one coordinate pair per cycle while the output is not held off and returns
// its great-circle distance in 1/16 m on a 6371008.8 m sphere through a 104-stage
// pipe; the result beat is registered at the end of the pipe.
// The latency is set by the chains that run one step per stage: four parallel
// 30-step rotation cordics for the sines and cosines, two 31-step restoring
// square roots for sqrt(h) and sqrt(1-h), and a 30-step vectoring cordic for
// the final atan2. Degrees turn into phase through an exact divide by 45
// (residue by 12-bit folding, then a modular-inverse multiply). Valid bits
// ride with the data; when the output beat is held off the whole pipe holds,
// so nothing is dropped or repeated, and in_ready is simply
// !out_valid || out_ready. The block keeps no state between beats and has no
// configuration.
module haversine_distance (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [hvd_pkg::LAT_W-1:0]  in_first_lat,
  input  logic signed [hvd_pkg::LON_W-1:0]  in_first_lon,
  input  logic signed [hvd_pkg::LAT_W-1:0]  in_second_lat,
  input  logic signed [hvd_pkg::LON_W-1:0]  in_second_lon,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [hvd_pkg::DIST_W-1:0] out_distance
);

  localparam int LAT_W = hvd_pkg::LAT_W;
  localparam int LON_W = hvd_pkg::LON_W;
  localparam int MW    = hvd_pkg::MW;
  localparam int CW    = hvd_pkg::CORDIC_W;
  localparam int CS    = hvd_pkg::CORDIC_STAGES;
  localparam int SQ_W  = hvd_pkg::SQ_W;
  localparam int SQS   = hvd_pkg::SQ_STEPS;
  localparam int Q_W   = hvd_pkg::Q_W;
  // m, residue sum, residue, exact-divide operand, phase, cordic, clamp,
  // two product stages, sqrt, vectoring, angle clamp, output
  localparam int LAT   = 5 + (CS + 1) + 1 + 2 + (SQS + 1) + (CS + 1) + 2;

  localparam logic signed [CW-1:0] Q1_CW  = CW'(hvd_pkg::Q30_ONE);
  localparam logic        [Q_W-1:0] Q1_Q  = Q_W'(hvd_pkg::Q30_ONE);

  // global advance: the whole pipe moves unless the output beat is stuck
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: scaled angle numerators
  // lanes: 0 = dlat/2, 1 = dlon/2, 2 = lat1, 3 = lat2
  // m = d * 2^(32-F) / (16 or 8) + floor(45/2), so phase = floor(m / 45)
  // ---------------------------------------------------------------------
  logic signed [LAT_W:0]  dlat;
  logic signed [LON_W:0]  dlon;
  logic signed [MW-1:0]   m_nxt [4];
  logic signed [MW-1:0]   m_r   [4];

  always_comb begin
    dlat     = (LAT_W+1)'(in_second_lat) - (LAT_W+1)'(in_first_lat);
    dlon     = (LON_W+1)'(in_second_lon) - (LON_W+1)'(in_first_lon);
    m_nxt[0] = (MW'(dlat) <<< hvd_pkg::SH_HALF) + MW'(hvd_pkg::PH_RND);
    m_nxt[1] = (MW'(dlon) <<< hvd_pkg::SH_HALF) + MW'(hvd_pkg::PH_RND);
    m_nxt[2] = (MW'(in_first_lat) <<< hvd_pkg::SH_FULL) + MW'(hvd_pkg::PH_RND);
    m_nxt[3] = (MW'(in_second_lat) <<< hvd_pkg::SH_FULL) + MW'(hvd_pkg::PH_RND);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stages 2..5: exact floor divide by 45, kept mod 2^32
  // r = m mod 45 by folding 12-bit chunks, then (m - r) * 45^-1 mod 2^32
  // ---------------------------------------------------------------------
  logic [hvd_pkg::SUM_W-1:0] s_r   [4];
  logic [31:0]               mlo_r [4];
  logic [hvd_pkg::R1_W-1:0]  r1_r  [4];
  logic [31:0]               mlo2_r[4];
  logic [31:0]               w_r   [4];
  logic [31:0]               ph_r  [4];

  // cordic rotation lanes
  logic signed [CW-1:0] cx_r [4][CS+1];
  logic signed [CW-1:0] cy_r [4][CS+1];
  logic signed [CW-1:0] cz_r [4][CS+1];
  logic                 cf_r [4][CS+1];
  logic signed [31:0]   sc_r [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [hvd_pkg::PAD_W-1:0]           mpad;
    logic [hvd_pkg::SUM_W-1:0]           s_nxt;
    logic [hvd_pkg::V_W-1:0]             v;
    logic [hvd_pkg::V_W+hvd_pkg::RCP_W-1:0] qprod;
    logic [hvd_pkg::QV_W-1:0]            qv;
    logic [hvd_pkg::V_W-1:0]             r1_full;
    logic [hvd_pkg::R_W-1:0]             r6;
    logic [31:0]                         ph_t;
    logic                                flip;
    logic [31:0]                         rr;
    logic signed [CW-1:0]                sv;
    logic signed [CW-1:0]                sc_nxt;

    // residue sum; a negative m is off by 2^MW, fixed by a constant
    always_comb begin
      mpad  = hvd_pkg::PAD_W'($unsigned(m_r[k]));
      s_nxt = hvd_pkg::SUM_W'(m_r[k][MW-1] ? hvd_pkg::NEG_ADJ : 0);
      for (int c = 0; c < hvd_pkg::NCH; c++) begin
        s_nxt = s_nxt + hvd_pkg::SUM_W'(mpad[c*hvd_pkg::CHUNK_W +: hvd_pkg::CHUNK_W]);
      end
    end

    // fold once more, then estimate the quotient by reciprocal
    always_comb begin
      v = hvd_pkg::V_W'(s_r[k][hvd_pkg::CHUNK_W-1:0])
        + hvd_pkg::V_W'(s_r[k][hvd_pkg::SUM_W-1:hvd_pkg::CHUNK_W]);
      qprod = (hvd_pkg::V_W+hvd_pkg::RCP_W)'(v)
            * (hvd_pkg::V_W+hvd_pkg::RCP_W)'(hvd_pkg::RECIP45);
      qv = qprod[hvd_pkg::RCP_SH +: hvd_pkg::QV_W];
      r1_full = v - hvd_pkg::V_W'(qv) * hvd_pkg::V_W'(hvd_pkg::DIV_CORE);
    end

    // estimate is low by at most one
    always_comb begin
      if (r1_r[k] >= hvd_pkg::R1_W'(hvd_pkg::DIV_CORE)) begin
        r6 = hvd_pkg::R_W'(r1_r[k] - hvd_pkg::R1_W'(hvd_pkg::DIV_CORE));
      end else begin
        r6 = hvd_pkg::R_W'(r1_r[k]);
      end
    end

    // fold the phase into quadrants one and four
    always_comb begin
      ph_t = ph_r[k] + 32'h4000_0000;
      flip = ph_t[31];
      rr   = flip ? (32'h8000_0000 - ph_r[k]) : ph_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k]       <= s_nxt;
        mlo_r[k]     <= m_r[k][31:0];
        r1_r[k]      <= r1_full[hvd_pkg::R1_W-1:0];
        mlo2_r[k]    <= mlo_r[k];
        w_r[k]       <= mlo2_r[k] - 32'(r6);
        ph_r[k]      <= w_r[k] * hvd_pkg::INV45;
        cx_r[k][0]   <= CW'(hvd_pkg::CORDIC_GAIN_Q30);
        cy_r[k][0]   <= '0;
        cz_r[k][0]   <= CW'($signed(rr));
        cf_r[k][0]   <= flip;
      end
    end

    // one rotation step per stage
    for (genvar i = 0; i < CS; i++) begin : g_rot
      always_ff @(posedge clk) begin
        if (en) begin
          if (!cz_r[k][i][CW-1]) begin
            cx_r[k][i+1] <= cx_r[k][i] - (cy_r[k][i] >>> i);
            cy_r[k][i+1] <= cy_r[k][i] + (cx_r[k][i] >>> i);
            cz_r[k][i+1] <= cz_r[k][i] - CW'(hvd_pkg::ATAN_PHASE[i]);
          end else begin
            cx_r[k][i+1] <= cx_r[k][i] + (cy_r[k][i] >>> i);
            cy_r[k][i+1] <= cy_r[k][i] - (cx_r[k][i] >>> i);
            cz_r[k][i+1] <= cz_r[k][i] + CW'(hvd_pkg::ATAN_PHASE[i]);
          end
          cf_r[k][i+1] <= cf_r[k][i];
        end
      end
    end

    // sine for the half-difference lanes, cosine for the latitude lanes
    always_comb begin
      if (k < 2) begin
        sv = cy_r[k][CS];
      end else if (cf_r[k][CS]) begin
        sv = -cx_r[k][CS];
      end else begin
        sv = cx_r[k][CS];
      end
      if (sv > Q1_CW) begin
        sc_nxt = Q1_CW;
      end else if (sv < -Q1_CW) begin
        sc_nxt = -Q1_CW;
      end else begin
        sc_nxt = sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sc_r[k] <= 32'(sc_nxt);
      end
    end
  end

  // ---------------------------------------------------------------------
  // products: sin^2 terms and the cosine product, then h
  // ---------------------------------------------------------------------
  logic signed [63:0]   p_sl, p_so, p_cc, p_ch;
  logic [Q_W-1:0]       sql_r, sqo_r, sql2_r;
  logic signed [31:0]   cc_r, p_r;
  logic signed [32:0]   hs;
  logic [Q_W-1:0]       hq;

  always_comb begin
    p_sl = sc_r[0] * sc_r[0];
    p_so = sc_r[1] * sc_r[1];
    p_cc = sc_r[2] * sc_r[3];
    p_ch = cc_r * $signed({1'b0, sqo_r});
    hs   = $signed({2'b00, sql2_r}) + 33'(p_r);
    if (hs < 0) begin
      hq = '0;
    end else if (hs > $signed({2'b00, Q1_Q})) begin
      hq = Q1_Q;
    end else begin
      hq = hs[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sql_r  <= p_sl[60:30];
      sqo_r  <= p_so[60:30];
      cc_r   <= p_cc[61:30];
      p_r    <= p_ch[61:30];
      sql2_r <= sql_r;
    end
  end

  // ---------------------------------------------------------------------
  // restoring square roots of h*2^60 and (1-h)*2^60, one bit per stage
  // lane 0 = sqrt(h), lane 1 = sqrt(1-h)
  // ---------------------------------------------------------------------
  logic [SQ_W-1:0] sn_r [2][SQS+1];
  logic [SQ_W-1:0] sr_r [2][SQS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r[0][0] <= {1'b0, hq, 30'b0};
      sn_r[1][0] <= {1'b0, Q1_Q - hq, 30'b0};
      sr_r[0][0] <= '0;
      sr_r[1][0] <= '0;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_sqrt
    for (genvar j = 0; j < SQS; j++) begin : g_bit
      localparam logic [SQ_W-1:0] SBIT = SQ_W'(1) << (2 * (SQS - 1 - j));
      always_ff @(posedge clk) begin
        if (en) begin
          if (sn_r[l][j] >= sr_r[l][j] + SBIT) begin
            sn_r[l][j+1] <= sn_r[l][j] - (sr_r[l][j] + SBIT);
            sr_r[l][j+1] <= (sr_r[l][j] >> 1) + SBIT;
          end else begin
            sn_r[l][j+1] <= sn_r[l][j];
            sr_r[l][j+1] <= sr_r[l][j] >> 1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // vectoring cordic: atan2(sqrt(h), sqrt(1-h)) in phase units
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] vx_r [CS+1];
  logic signed [CW-1:0] vy_r [CS+1];
  logic signed [CW-1:0] vz_r [CS+1];
  logic                 vzero_r [CS+1];
  logic [Q_W-1:0]       ang_nxt;
  logic [Q_W-1:0]       ang_r;
  logic [hvd_pkg::DPROD_W-1:0] dprod;
  logic [hvd_pkg::DIST_W-1:0]  out_distance_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0]    <= CW'(sr_r[1][SQS]);
      vy_r[0]    <= CW'(sr_r[0][SQS]);
      vz_r[0]    <= '0;
      vzero_r[0] <= (sr_r[0][SQS] == '0);
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy_r[i] > 0) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + CW'(hvd_pkg::ATAN_PHASE[i]);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - CW'(hvd_pkg::ATAN_PHASE[i]);
        end
        vzero_r[i+1] <= vzero_r[i];
      end
    end
  end

  // coincident points give exactly zero; clamp to a quarter turn
  always_comb begin
    if (vzero_r[CS] || vz_r[CS] < 0) begin
      ang_nxt = '0;
    end else if (vz_r[CS] > Q1_CW) begin
      ang_nxt = Q1_Q;
    end else begin
      ang_nxt = vz_r[CS][Q_W-1:0];
    end
    dprod = hvd_pkg::DPROD_W'(ang_r) * hvd_pkg::DPROD_W'(hvd_pkg::DIST_SCALE)
          + (hvd_pkg::DPROD_W'(1) << 31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r          <= ang_nxt;
      out_distance_r <= dprod[32 +: hvd_pkg::DIST_W];
    end
  end

  assign out_distance = out_distance_r;

endmodule

`default_nettype wire

[design/hvd_check.sv]
// hvd_check: port-level checks on haversine_distance, attached by bind
// depends on hvd_pkg
`timescale 1ns / 1ps
`default_nettype none

module hvd_check (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic        [hvd_pkg::DIST_W-1:0] out_distance
);

  // a held result beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance))
    else $error("result beat changed while stalled");

  // input side only stalls when a result is waiting
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  // distance never exceeds half the circumference
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance <= hvd_pkg::DIST_W'(hvd_pkg::DIST_MAX))
    else $error("distance out of range");

  // pipe comes out of reset empty
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind haversine_distance hvd_check u_hvd_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_distance (out_distance)
);

`default_nettype wire
